// File: hw/rtl/arfq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Acknowledged retransmit frame queue: shared definitions
// Sizes, request codes, the send job handed from front to back, and the
// state type of the transmit sequencer.
// ----------------------------------------------------------------------------
package arfq_pkg;

  // Ring size and payload limit.
  localparam int QUEUE_DEPTH = 8;
  localparam int MAX_PAYLOAD = 32;

  // One spare slot, so the frame being built never lands on a live frame.
  localparam int NUM_SLOTS = QUEUE_DEPTH + 1;
  localparam int SLOT_W    = $clog2(NUM_SLOTS);
  localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);

  // Payload byte index inside a slot, and the count of bytes built so far.
  localparam int PIDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int PLEN_W = $clog2(MAX_PAYLOAD + 1);

  // Length byte value is payload + 2; a frame carries that many bytes plus one.
  localparam int FRAME_OVERHEAD = 2;
  localparam int FLEN_W         = $clog2(MAX_PAYLOAD + FRAME_OVERHEAD + 1);

  // Payload store: one row of 2**PIDX_W bytes per slot.
  localparam int RAM_DEPTH = NUM_SLOTS << PIDX_W;
  localparam int RAM_AW    = SLOT_W + PIDX_W;

  localparam logic [7:0] RETRY_RESET = 8'd3;

  typedef enum logic [1:0] {
    FUNC_BEGIN = 2'd0,
    FUNC_DATA  = 2'd1,
    FUNC_ACK   = 2'd2,
    FUNC_POLL  = 2'd3
  } func_t;

  // Everything the back end needs to stream one frame.
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [FLEN_W-1:0] flen;
    logic [7:0]        cmd;
    logic [7:0]        chk;
  } send_job_t;

  typedef logic [NUM_SLOTS-1:0] slot_mask_t;

  typedef enum logic {
    TX_IDLE = 1'b0,
    TX_SEND = 1'b1
  } tx_state_t;

endpackage

// File: hw/rtl/arfq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered, enable-gated read data.
// ----------------------------------------------------------------------------
module arfq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; data holds while the enable is low.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hw/rtl/arfq_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Front end: request decode and queue bookkeeping
// Builds frames into the payload store, keeps the ring pointers and per-slot
// header bytes, handles acks, and turns firing polls into send jobs.
// ----------------------------------------------------------------------------
module arfq_front import arfq_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [1:0]          func,
  input  logic [7:0]          cmd,
  input  logic [7:0]          data_byte,
  input  logic                last,
  input  logic [7:0]          seconds_passed,
  input  logic                cfg_wr_en,
  input  logic [7:0]          cfg_wr_data,
  input  slot_mask_t          busy_mask,
  input  logic                jq_full,
  output logic                jq_push,
  output send_job_t           jq_job,
  output logic                ram_we,
  output logic [RAM_AW-1:0]   ram_waddr,
  output logic [7:0]          ram_wdata
);

  typedef struct packed {
    logic [FLEN_W-1:0] flen;
    logic [7:0]        cmd;
    logic [7:0]        chk;
  } slot_meta_t;

  logic              accept;
  logic [7:0]        retry;
  logic [SLOT_W-1:0] rd, rd_next;
  logic [SLOT_W-1:0] wr, wr_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [CNT_W-1:0]  reported, reported_next;
  logic [31:0]       secs, secs_next;
  logic [PLEN_W-1:0] build_len, build_len_next;
  logic [7:0]        build_xor, build_xor_next;
  logic              building, building_next;
  logic [7:0]        stage_cmd, stage_cmd_next;
  logic              commit;
  logic              fire;
  logic [32:0]       secs_raw;
  logic [31:0]       secs_sum;
  logic [FLEN_W-1:0] commit_flen;
  slot_meta_t        slot_meta [NUM_SLOTS];

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] r;
    if (s == SLOT_W'(NUM_SLOTS - 1)) begin
      r = '0;
    end else begin
      r = s + SLOT_W'(1);
    end
    return r;
  endfunction

  // Hold off while the job queue is full or the build slot is still read by a waiting or active send.
  assign full   = jq_full | busy_mask[wr];
  assign accept = push & ~full;

  // Saturating time accumulation.
  assign secs_raw = {1'b0, secs} + 33'(seconds_passed);
  assign secs_sum = secs_raw[32] ? '1 : secs_raw[31:0];

  // Payload bytes go straight into the build slot.
  assign ram_waddr = {wr, build_len[PIDX_W-1:0]};
  assign ram_wdata = data_byte;

  assign commit_flen = FLEN_W'(build_len_next) + FLEN_W'(FRAME_OVERHEAD);

  // The send job always describes the head frame.
  assign jq_job.slot = rd;
  assign jq_job.flen = slot_meta[rd].flen;
  assign jq_job.cmd  = slot_meta[rd].cmd;
  assign jq_job.chk  = slot_meta[rd].chk;

  // Request decode and next state.
  always_comb begin
    rd_next        = rd;
    wr_next        = wr;
    count_next     = count;
    reported_next  = reported;
    secs_next      = secs;
    build_len_next = build_len;
    build_xor_next = build_xor;
    building_next  = building;
    stage_cmd_next = stage_cmd;
    commit         = 1'b0;
    fire           = 1'b0;
    ram_we         = 1'b0;
    jq_push        = 1'b0;
    if (accept) begin
      case (func_t'(func))
        FUNC_BEGIN: begin
          building_next  = 1'b1;
          stage_cmd_next = cmd;
          build_len_next = '0;
          build_xor_next = cmd;
          commit         = last;
        end
        FUNC_DATA: begin
          if (building) begin
            if (build_len < PLEN_W'(MAX_PAYLOAD)) begin
              ram_we         = 1'b1;
              build_xor_next = build_xor ^ data_byte;
              build_len_next = build_len + PLEN_W'(1);
            end
            commit = last;
          end
        end
        FUNC_ACK: begin
          if (count != '0 && slot_meta[rd].cmd == cmd) begin
            count_next = count - CNT_W'(1);
            rd_next    = slot_inc(rd);
          end
        end
        FUNC_POLL: begin
          if (reported != count) begin
            reported_next = count;
            fire          = 1'b1;
          end else if (count != '0 && secs_sum > 32'(retry)) begin
            fire = 1'b1;
          end
          if (fire) begin
            secs_next = '0;
            jq_push   = (count != '0);
          end else begin
            secs_next = secs_sum;
          end
        end
        default: begin
        end
      endcase
    end
    // Commit: the build slot joins the ring, dropping the oldest if full.
    if (commit) begin
      building_next = 1'b0;
      wr_next       = slot_inc(wr);
      if (count == CNT_W'(QUEUE_DEPTH)) begin
        rd_next = slot_inc(rd);
      end else begin
        count_next = count + CNT_W'(1);
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd        <= '0;
      wr        <= '0;
      count     <= '0;
      reported  <= '0;
      secs      <= '1;
      build_len <= '0;
      build_xor <= '0;
      building  <= 1'b0;
      stage_cmd <= '0;
      retry     <= RETRY_RESET;
    end else begin
      rd        <= rd_next;
      wr        <= wr_next;
      count     <= count_next;
      reported  <= reported_next;
      secs      <= secs_next;
      build_len <= build_len_next;
      build_xor <= build_xor_next;
      building  <= building_next;
      stage_cmd <= stage_cmd_next;
      if (cfg_wr_en) begin
        retry <= cfg_wr_data;
      end
    end
  end

  // Header bytes of a committed frame.
  always_ff @(posedge clk) begin
    if (commit) begin
      slot_meta[wr].flen <= commit_flen;
      slot_meta[wr].cmd  <= stage_cmd_next;
      slot_meta[wr].chk  <= build_xor_next ^ 8'(commit_flen);
    end
  end

endmodule

// File: hw/rtl/arfq_jobq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Send job queue
// Two-entry queue of send jobs between the front and back ends; also reports
// which slots its waiting jobs still refer to.
// ----------------------------------------------------------------------------
module arfq_jobq import arfq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  send_job_t  push_job,
  output logic       full,
  input  logic       pop,
  output logic       valid,
  output send_job_t  head_job,
  output slot_mask_t busy_mask
);

  logic      v0, v1;
  send_job_t e0, e1;

  assign valid    = v0;
  assign full     = v1;
  assign head_job = e0;

  // Slots referenced by waiting jobs.
  always_comb begin
    busy_mask = '0;
    if (v0) begin
      busy_mask[e0.slot] = 1'b1;
    end
    if (v1) begin
      busy_mask[e1.slot] = 1'b1;
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else if (push && pop) begin
      v0 <= 1'b1;
    end else if (pop) begin
      v0 <= v1;
      v1 <= 1'b0;
    end else if (push) begin
      v0 <= 1'b1;
      v1 <= v0;
    end
  end

  // Entries; the head is always entry zero.
  always_ff @(posedge clk) begin
    if (push && pop) begin
      if (v1) begin
        e0 <= e1;
        e1 <= push_job;
      end else begin
        e0 <= push_job;
      end
    end else if (pop) begin
      e0 <= e1;
    end else if (push) begin
      if (v0) begin
        e1 <= push_job;
      end else begin
        e0 <= push_job;
      end
    end
  end

endmodule

// File: hw/rtl/arfq_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Back end: frame transmitter
// Takes one send job at a time and streams length, command, payload and
// checksum bytes into the output register, one byte per free output cycle.
// ----------------------------------------------------------------------------
module arfq_back import arfq_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              jq_valid,
  input  send_job_t         jq_job,
  output logic              jq_pop,
  output slot_mask_t        busy_mask,
  output logic              ram_re,
  output logic [RAM_AW-1:0] ram_raddr,
  input  logic [7:0]        ram_rdata,
  output logic              empty,
  input  logic              pop,
  output logic [7:0]        frame_byte,
  output logic              frame_end
);

  tx_state_t         state, state_next;
  send_job_t         job;
  logic [FLEN_W-1:0] idx, idx_next;
  logic [FLEN_W-1:0] idx_prev;
  logic              out_valid;
  logic              load;
  logic [7:0]        byte_sel;
  logic              end_sel;

  assign empty = ~out_valid;

  // Load the output register when it is free or being taken this cycle.
  assign load = (state == TX_SEND) && (!out_valid || pop);

  // Prefetch the payload byte needed by the following load.
  assign idx_prev  = idx - FLEN_W'(1);
  assign ram_re    = load;
  assign ram_raddr = {job.slot, idx_prev[PIDX_W-1:0]};

  // Byte selection by position in the frame.
  always_comb begin
    end_sel = 1'b0;
    if (idx == '0) begin
      byte_sel = 8'(job.flen);
    end else if (idx == FLEN_W'(1)) begin
      byte_sel = job.cmd;
    end else if (idx == job.flen) begin
      byte_sel = job.chk;
      end_sel  = 1'b1;
    end else begin
      byte_sel = ram_rdata;
    end
  end

  // Sequencer next state.
  always_comb begin
    state_next = state;
    idx_next   = idx;
    jq_pop     = 1'b0;
    busy_mask  = '0;
    case (state)
      TX_IDLE: begin
        if (jq_valid) begin
          jq_pop     = 1'b1;
          idx_next   = '0;
          state_next = TX_SEND;
        end
      end
      TX_SEND: begin
        busy_mask[job.slot] = 1'b1;
        if (load) begin
          idx_next = idx + FLEN_W'(1);
          if (end_sel) begin
            state_next = TX_IDLE;
          end
        end
      end
      default: begin
        state_next = TX_IDLE;
      end
    endcase
  end

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= TX_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    if (jq_pop) begin
      job <= jq_job;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frame_byte <= byte_sel;
      frame_end  <= end_sel;
    end
  end

endmodule

// File: hw/rtl/ack_retransmit_frame_queue_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Acknowledged retransmit frame queue
// Builds checksummed frames, keeps them in a ring that drops its oldest frame
// when full, removes the head on a matching ack and retransmits it on poll.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake          Contents
//  request   in         push / full        func, cmd, data_byte, last, seconds_passed
//  frame     out        empty / pop        frame_byte, frame_end
//  config    in         cfg_wr_en          cfg_wr_data (retry time in seconds)
//
// A request is taken whenever push is high and full is low. A poll that sends
// queues a job, and the transmitter streams that frame (payload + 3 bytes)
// at one byte per cycle while the output register is free or being popped.
// full rises while two send jobs wait, or while the slot now being built is
// still read by a waiting or active send. The payload store is not cleared
// on reset, since only slots that hold a committed frame are read.
module ack_retransmit_frame_queue_core import arfq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [1:0] func,
  input  logic [7:0] cmd,
  input  logic [7:0] data_byte,
  input  logic       last,
  input  logic [7:0] seconds_passed,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] frame_byte,
  output logic       frame_end,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);

  logic              jq_push, jq_pop, jq_full, jq_valid;
  send_job_t         jq_in_job, jq_head_job;
  slot_mask_t        jq_busy, tx_busy, busy_mask;
  logic              ram_we, ram_re;
  logic [RAM_AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]        ram_wdata, ram_rdata;

  // Slots that a waiting or active send still reads.
  assign busy_mask = jq_busy | tx_busy;

  // Request decode and ring bookkeeping.
  arfq_front u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .func           (func),
    .cmd            (cmd),
    .data_byte      (data_byte),
    .last           (last),
    .seconds_passed (seconds_passed),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .busy_mask      (busy_mask),
    .jq_full        (jq_full),
    .jq_push        (jq_push),
    .jq_job         (jq_in_job),
    .ram_we         (ram_we),
    .ram_waddr      (ram_waddr),
    .ram_wdata      (ram_wdata)
  );

  // Send jobs between front and back.
  arfq_jobq u_jobq (
    .clk       (clk),
    .rst       (rst),
    .push      (jq_push),
    .push_job  (jq_in_job),
    .full      (jq_full),
    .pop       (jq_pop),
    .valid     (jq_valid),
    .head_job  (jq_head_job),
    .busy_mask (jq_busy)
  );

  // Payload store.
  arfq_ram #(
    .WIDTH (8),
    .DEPTH (RAM_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // Frame transmitter.
  arfq_back u_back (
    .clk        (clk),
    .rst        (rst),
    .jq_valid   (jq_valid),
    .jq_job     (jq_head_job),
    .jq_pop     (jq_pop),
    .busy_mask  (tx_busy),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .empty      (empty),
    .pop        (pop),
    .frame_byte (frame_byte),
    .frame_end  (frame_end)
  );

  // A send job is only queued when there is room for it.
  assert property (@(posedge clk) disable iff (rst) jq_push |-> !jq_full)
    else $error("send job queued into a full job queue");

  // The transmitter only takes a job that is waiting.
  assert property (@(posedge clk) disable iff (rst) jq_pop |-> jq_valid)
    else $error("transmitter took a job from an empty queue");

  // Payload writes never touch a slot that a send still reads.
  assert property (@(posedge clk) disable iff (rst)
    ram_we |-> !busy_mask[ram_waddr[RAM_AW-1:PIDX_W]])
    else $error("payload write into a slot that is being transmitted");

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the acknowledged retransmit frame queue
// Drives begin, payload, ack and poll requests through the push/full port and
// predicts every transmitted byte with an independent model of the ring. The
// model covers framing, checksums, oldest-frame drop, acks and retry timing.
// Frame bytes are popped with random stalls and compared in order. The run
// covers several retry settings, idle patterns and one long output hold-off
// that backs the block up into its input.
// ----------------------------------------------------------------------------
module tb;
  import arfq_pkg::*;

  localparam int SLOT_BYTES  = MAX_PAYLOAD + 3;
  localparam int SETTLE      = 2 * SLOT_BYTES;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 10;

  typedef struct {
    func_t      f;
    logic [7:0] cmd;
    logic [7:0] data;
    logic       last;
    logic [7:0] secs;
  } request_t;

  typedef struct {
    logic [7:0] b;
    logic       e;
  } tx_byte_t;

  // Clock, reset and block ports.
  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  logic [1:0] func = FUNC_BEGIN;
  logic [7:0] cmd = 8'h00;
  logic [7:0] data_byte = 8'h00;
  logic       last = 1'b0;
  logic [7:0] seconds_passed = 8'h00;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] frame_byte;
  logic       frame_end;
  logic       cfg_wr_en = 1'b0;
  logic [7:0] cfg_wr_data = 8'h00;

  // Shared bench state.
  int       errors = 0;
  int       cycle_count = 0;
  int       idle_pct = 0;
  int       stall_pct = 0;
  int       hold_len = 0;
  int       hold_left = 0;
  tx_byte_t tx_bytes_due[$];

  // Predicted state of the ring and of the message under construction.
  logic [7:0]  ring_bytes [QUEUE_DEPTH][SLOT_BYTES];
  logic [7:0]  ring_len [QUEUE_DEPTH];
  int unsigned rd_idx = 0;
  int unsigned wr_idx = 0;
  int unsigned q_count = 0;
  int unsigned reported = 0;
  logic [31:0] since_send = 32'hFFFF_FFFF;
  int unsigned build_len = 0;
  logic [7:0]  build_xor = 8'h00;
  logic        building = 1'b0;
  logic [7:0]  stage_cmd = 8'h00;
  logic [7:0]  stage_payload [MAX_PAYLOAD];
  logic [7:0]  retry_limit = RETRY_RESET;

  ack_retransmit_frame_queue_core uut (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .func           (func),
    .cmd            (cmd),
    .data_byte      (data_byte),
    .last           (last),
    .seconds_passed (seconds_passed),
    .empty          (empty),
    .pop            (pop),
    .frame_byte     (frame_byte),
    .frame_end      (frame_end),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  always #5 clk = ~clk;

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[ack_retransmit_frame_queue_core] ERROR");
      $finish;
    end
  end

  // Receiver: random stalls, plus a counted hold-off when a test requests one.
  always @(posedge clk) begin
    if (hold_len != 0) begin
      hold_left = hold_len;
      hold_len = 0;
    end
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Compare each popped byte with the oldest predicted byte.
  always @(posedge clk) begin : check_frames
    tx_byte_t want;
    if (!rst && pop && !empty) begin
      if (tx_bytes_due.size() == 0) begin
        $display("%0t: unexpected frame byte, expected none, actual %02h end %b",
                 $time, frame_byte, frame_end);
        errors++;
      end else begin
        want = tx_bytes_due.pop_front();
        if (frame_byte !== want.b) begin
          $display("%0t: frame_byte expected %02h actual %02h", $time, want.b, frame_byte);
          errors++;
        end
        if (frame_end !== want.e) begin
          $display("%0t: frame_end expected %b actual %b", $time, want.e, frame_end);
          errors++;
        end
      end
    end
  end

  // Move the message under construction into the ring, dropping the oldest
  // frame when the ring is already full.
  function automatic void commit_frame();
    int unsigned dl;
    dl = build_len + 2;
    if (q_count >= QUEUE_DEPTH) rd_idx = (rd_idx + 1) % QUEUE_DEPTH;
    else q_count++;
    ring_bytes[wr_idx][0] = 8'(dl);
    ring_bytes[wr_idx][1] = stage_cmd;
    for (int i = 0; i < build_len; i++) ring_bytes[wr_idx][2 + i] = stage_payload[i];
    ring_bytes[wr_idx][dl] = build_xor ^ 8'(dl);
    ring_len[wr_idx] = 8'(dl);
    wr_idx = (wr_idx + 1) % QUEUE_DEPTH;
    building = 1'b0;
  endfunction

  // Advance the predicted queue by one accepted request and record the bytes
  // that a firing poll puts on the wire.
  function automatic void step_frame_queue(request_t r);
    logic [32:0] sum;
    logic        fire;
    int unsigned total;
    tx_byte_t    tb_byte;
    case (r.f)
      FUNC_BEGIN: begin
        building = 1'b1;
        stage_cmd = r.cmd;
        build_len = 0;
        build_xor = r.cmd;
        if (r.last) commit_frame();
      end
      FUNC_DATA: begin
        if (building) begin
          if (build_len < MAX_PAYLOAD) begin
            stage_payload[build_len] = r.data;
            build_xor ^= r.data;
            build_len++;
          end
          if (r.last) commit_frame();
        end
      end
      FUNC_ACK: begin
        if (q_count > 0 && ring_bytes[rd_idx][1] == r.cmd) begin
          q_count--;
          rd_idx = (rd_idx + 1) % QUEUE_DEPTH;
        end
      end
      default: begin
        // Seconds accumulate and saturate at all ones.
        sum = {1'b0, since_send} + r.secs;
        since_send = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        fire = 1'b0;
        if (reported != q_count) begin
          reported = q_count;
          fire = 1'b1;
        end else if (q_count > 0 && since_send > retry_limit) begin
          fire = 1'b1;
        end
        if (fire) begin
          since_send = 0;
          if (q_count > 0) begin
            total = ring_len[rd_idx] + 1;
            for (int k = 0; k < total; k++) begin
              tb_byte.b = ring_bytes[rd_idx][k];
              tb_byte.e = (k + 1 == total);
              tx_bytes_due.push_back(tb_byte);
            end
          end
        end
      end
    endcase
  endfunction

  // Offer one request after a random idle gap and wait until it is taken.
  // push stays high afterwards so the next request can follow back to back.
  task automatic send_req(input func_t f, input logic [7:0] c, input logic [7:0] d,
                          input logic l, input logic [7:0] s);
    request_t r;
    int       gap;
    gap = 0;
    while (gap < 16 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    r.f = f;
    r.cmd = c;
    r.data = d;
    r.last = l;
    r.secs = s;
    push <= 1'b1;
    func <= f;
    cmd <= c;
    data_byte <= d;
    last <= l;
    seconds_passed <= s;
    @(posedge clk);
    while (full) @(posedge clk);
    step_frame_queue(r);
  endtask

  // Stop offering requests, let every predicted byte drain, then let the
  // block settle.
  task automatic wait_idle();
    push <= 1'b0;
    while (tx_bytes_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_retry(input logic [7:0] value);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    retry_limit = value;
  endtask

  // Edge cases around empty queues, restarts, stray requests and retry timing.
  task automatic test_basic_requests();
    send_req(FUNC_POLL, 8'h00, 8'h00, 1'b0, 8'd0);
    send_req(FUNC_DATA, 8'h00, 8'hFF, 1'b1, 8'd0);
    send_req(FUNC_BEGIN, 8'hFF, 8'h00, 1'b1, 8'd0);
    send_req(FUNC_POLL, 8'h00, 8'h00, 1'b0, 8'd0);
    send_req(FUNC_ACK, 8'h00, 8'h00, 1'b0, 8'd0);
    send_req(FUNC_ACK, 8'hFF, 8'h00, 1'b1, 8'd0);
    // The count changed to zero, so this poll fires but sends nothing.
    send_req(FUNC_POLL, 8'h00, 8'h00, 1'b0, 8'd255);
    send_req(FUNC_ACK, 8'hFF, 8'h00, 1'b0, 8'd0);
    send_req(FUNC_BEGIN, 8'h00, 8'h00, 1'b0, 8'd0);
    send_req(FUNC_DATA, 8'h00, 8'hAA, 1'b0, 8'd0);
    // A new begin throws away the unfinished message.
    send_req(FUNC_BEGIN, 8'h5A, 8'h00, 1'b0, 8'd0);
    send_req(FUNC_DATA, 8'h00, 8'h00, 1'b0, 8'd0);
    send_req(FUNC_DATA, 8'hFF, 8'hFF, 1'b1, 8'd0);
    send_req(FUNC_POLL, 8'h00, 8'h00, 1'b0, 8'd1);
    send_req(FUNC_POLL, 8'h00, 8'h00, 1'b0, 8'd2);
    send_req(FUNC_POLL, 8'h00, 8'h00, 1'b0, 8'd2);
    send_req(FUNC_POLL, 8'hFF, 8'hFF, 1'b1, 8'd0);
    send_req(FUNC_POLL, 8'h00, 8'h00, 1'b0, 8'd255);
    send_req(FUNC_ACK, 8'h5A, 8'h00, 1'b1, 8'd0);
    send_req(FUNC_POLL, 8'h00, 8'h00, 1'b0, 8'd0);
    wait_idle();
  endtask

  // Overfill the ring so the oldest frames are dropped, then ack it empty.
  task automatic test_ring_overwrite();
    for (int i = 0; i < QUEUE_DEPTH + 2; i++)
      send_req(FUNC_BEGIN, 8'(8'h10 + i), 8'h00, 1'b1, 8'd0);
    send_req(FUNC_POLL, 8'h00, 8'h00, 1'b0, 8'd0);
    while (q_count > 0) begin
      send_req(FUNC_ACK, ring_bytes[rd_idx][1], 8'h00, 1'b0, 8'd0);
      send_req(FUNC_POLL, 8'h00, 8'h00, 1'b0, 8'd0);
    end
    wait_idle();
  endtask

  // A frame that fills the payload limit and goes on; the extra bytes are dropped.
  task automatic test_long_frames();
    send_req(FUNC_BEGIN, 8'hA5, 8'h00, 1'b0, 8'd0);
    for (int i = 0; i < MAX_PAYLOAD + 2; i++)
      send_req(FUNC_DATA, 8'h00, 8'($urandom_range(255)), i == MAX_PAYLOAD + 1, 8'd0);
    send_req(FUNC_POLL, 8'h00, 8'h00, 1'b0, 8'd0);
    send_req(FUNC_ACK, 8'hA5, 8'h00, 1'b0, 8'd0);
    send_req(FUNC_POLL, 8'h00, 8'h00, 1'b0, 8'd0);
    wait_idle();
  endtask

  // Hold the output off while polls keep firing, so the block stalls its input.
  task automatic test_input_backpressure();
    idle_pct = 0;
    stall_pct = 0;
    set_retry(8'd0);
    send_req(FUNC_BEGIN, 8'h33, 8'h00, 1'b0, 8'd0);
    for (int i = 0; i < 8; i++)
      send_req(FUNC_DATA, 8'h00, 8'($urandom_range(255)), i == 7, 8'd0);
    hold_len = 400;
    for (int i = 0; i < 12; i++)
      send_req(FUNC_POLL, 8'h00, 8'h00, 1'b0, 8'd1);
    send_req(FUNC_ACK, 8'h33, 8'h00, 1'b0, 8'd0);
    send_req(FUNC_POLL, 8'h00, 8'h00, 1'b0, 8'd0);
    wait_idle();
  endtask

  // Mostly well-formed messages with acks and polls, plus some raw noise.
  task automatic test_random_traffic(input int sender_idle, input int receiver_stall,
                                     input logic [7:0] retry);
    int         sent;
    int         pick;
    int         len;
    logic [7:0] ack_cmd;
    set_retry(retry);
    idle_pct = sender_idle;
    stall_pct = receiver_stall;
    sent = 0;
    while (sent < PHASE_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(MAX_PAYLOAD + 3) : $urandom_range(4);
        send_req(FUNC_BEGIN, 8'($urandom_range(255)), 8'($urandom_range(255)),
                 len == 0, 8'($urandom_range(255)));
        for (int i = 0; i < len; i++)
          send_req(FUNC_DATA, 8'($urandom_range(255)), 8'($urandom_range(255)),
                   i == len - 1, 8'($urandom_range(255)));
        sent += len + 1;
      end else if (pick < 65) begin
        if (q_count > 0 && $urandom_range(3) != 0) ack_cmd = ring_bytes[rd_idx][1];
        else ack_cmd = 8'($urandom_range(255));
        send_req(FUNC_ACK, ack_cmd, 8'($urandom_range(255)), 1'($urandom_range(1)), 8'd0);
        sent++;
      end else if (pick < 88) begin
        send_req(FUNC_POLL, 8'($urandom_range(255)), 8'($urandom_range(255)),
                 1'($urandom_range(1)),
                 ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(4)));
        sent++;
      end else begin
        send_req(func_t'($urandom_range(3)), 8'($urandom_range(255)),
                 8'($urandom_range(255)), 1'($urandom_range(1)), 8'($urandom_range(255)));
        sent++;
      end
    end
    wait_idle();
  endtask

  // Test sequence.
  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_basic_requests();
    test_ring_overwrite();
    test_long_frames();
    test_input_backpressure();
    test_random_traffic(0, 0, 8'd0);
    test_random_traffic(63, 0, 8'd255);
    test_random_traffic(0, 63, 8'($urandom_range(255)));
    test_random_traffic(31, 31, 8'd1);
    wait_idle();
    if (errors == 0) begin
      $display("[ack_retransmit_frame_queue_core] OK");
    end else begin
      $display("[ack_retransmit_frame_queue_core] ERROR");
    end
    $finish;
  end

endmodule

// File: ack_retransmit_frame_queue_core.f
hw/rtl/arfq_pkg.sv
hw/rtl/arfq_ram.sv
hw/rtl/arfq_front.sv
hw/rtl/arfq_jobq.sv
hw/rtl/arfq_back.sv
hw/rtl/ack_retransmit_frame_queue_core.sv
tb/tb.sv
